// ===== rtl/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU recency tracker package
// Operation and status codes and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int FRAME_BITS = 4;

  typedef logic [1:0] func_t;
  typedef logic [1:0] status_t;

  localparam func_t FUNC_TOUCH     = 2'd0;
  localparam func_t FUNC_REMOVE    = 2'd1;
  localparam func_t FUNC_SET_DIRTY = 2'd2;
  localparam func_t FUNC_CLR_DIRTY = 2'd3;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NOT_FOUND = 2'd1;
  localparam status_t STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic                  en;
    func_t                 func;
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
    logic                  full;
  } cell_ctl_t;

endpackage

// ===== rtl/lru_recency_tracker.sv =====
// ----------------------------------------------------------------------------
// LRU recency tracker
// Recency-ordered list of buffer frames held in a row of cells; reports the
// least recently used entry as the victim after every operation.
// ----------------------------------------------------------------------------
// Result path: the cell update, then the victim select into the output
//   register, where the result waits while m_axis_tready is low.
// Throughput: one operation per cycle while m_axis_tready does not stall the
//   output; the cell row compares and shifts at once, so it sets the rate.
// Reset: clears every cell's valid bit and both pipeline stages.
module lru_recency_tracker #(
  parameter int ENTRIES   = 16,
  parameter int PAGE_BITS = 20
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               s_axis_tvalid,
  output logic                                               s_axis_tready,
  // frame, page
  input  logic [((lrt_pkg::FRAME_BITS + PAGE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // func
  input  lrt_pkg::func_t                                     s_axis_tuser,
  output logic                                               m_axis_tvalid,
  input  logic                                               m_axis_tready,
  // status, hit, victim_valid, victim_frame, victim_page, victim_dirty
  output logic [((lrt_pkg::FRAME_BITS + PAGE_BITS + 12) / 8) * 8 - 1:0] m_axis_tdata
);
  import lrt_pkg::*;

  localparam int OUT_W = ((FRAME_BITS + PAGE_BITS + 12) / 8) * 8;

  logic                  accept;
  logic                  load;
  func_t                 func;
  logic [FRAME_BITS-1:0] in_frame;
  logic [PAGE_BITS-1:0]  in_page;
  logic                  hit;
  logic                  full;
  cell_ctl_t             ctl;

  logic [ENTRIES-1:0]    c_valid;
  logic [FRAME_BITS-1:0] c_frame [ENTRIES];
  logic [PAGE_BITS-1:0]  c_page  [ENTRIES];
  logic [ENTRIES-1:0]    c_dirty;
  logic [ENTRIES-1:0]    match;
  logic [ENTRIES:0]      above;
  logic [ENTRIES-1:0]    tail;

  logic [PAGE_BITS-1:0]  hit_page;
  logic                  hit_dirty;
  logic [PAGE_BITS-1:0]  head_page;
  logic                  head_dirty;

  logic                  pend;
  status_t               st_status;
  status_t               st_status_next;
  logic                  st_hit;

  logic [FRAME_BITS-1:0] v_frame;
  logic [PAGE_BITS-1:0]  v_page;
  logic                  v_dirty;
  logic [OUT_W-1:0]      out_word;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign func     = s_axis_tuser;
  assign in_frame = s_axis_tdata[FRAME_BITS-1:0];
  assign in_page  = s_axis_tdata[FRAME_BITS +: PAGE_BITS];

  assign above[0] = 1'b0;
  assign hit      = above[ENTRIES];
  assign full     = c_valid[ENTRIES-1];

  assign ctl.en    = accept;
  assign ctl.func  = func;
  assign ctl.frame = in_frame;
  assign ctl.hit   = hit;
  assign ctl.full  = full;

  always_comb begin
    hit_page  = '0;
    hit_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_page  = hit_page | (c_page[i] & {PAGE_BITS{match[i]}});
      hit_dirty = hit_dirty | (c_dirty[i] & match[i]);
    end
  end

  assign head_page  = hit ? hit_page : in_page;
  assign head_dirty = hit ? hit_dirty : 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                  p_valid;
    logic [FRAME_BITS-1:0] p_frame;
    logic [PAGE_BITS-1:0]  p_page;
    logic                  p_dirty;
    logic                  n_valid;
    logic [FRAME_BITS-1:0] n_frame;
    logic [PAGE_BITS-1:0]  n_page;
    logic                  n_dirty;

    if (i == 0) begin : g_head
      assign p_valid = 1'b1;
      assign p_frame = in_frame;
      assign p_page  = head_page;
      assign p_dirty = head_dirty;
    end else begin : g_mid
      assign p_valid = c_valid[i-1];
      assign p_frame = c_frame[i-1];
      assign p_page  = c_page[i-1];
      assign p_dirty = c_dirty[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_frame = '0;
      assign n_page  = '0;
      assign n_dirty = 1'b0;
      assign tail[i] = c_valid[i];
    end else begin : g_inner
      assign n_valid = c_valid[i+1];
      assign n_frame = c_frame[i+1];
      assign n_page  = c_page[i+1];
      assign n_dirty = c_dirty[i+1];
      assign tail[i] = c_valid[i] && !c_valid[i+1];
    end

    lrt_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (p_valid),
      .prev_frame (p_frame),
      .prev_page  (p_page),
      .prev_dirty (p_dirty),
      .next_valid (n_valid),
      .next_frame (n_frame),
      .next_page  (n_page),
      .next_dirty (n_dirty),
      .before_in  (above[i]),
      .before_out (above[i+1]),
      .match      (match[i]),
      .valid      (c_valid[i]),
      .frame      (c_frame[i]),
      .page       (c_page[i]),
      .dirty      (c_dirty[i])
    );
  end

  always_comb begin
    st_status_next = STATUS_OK;
    if (func == FUNC_TOUCH && !hit && full) begin
      st_status_next = STATUS_FULL;
    end else if (func == FUNC_REMOVE && !hit) begin
      st_status_next = STATUS_NOT_FOUND;
    end
  end

  always_comb begin
    v_frame = '0;
    v_page  = '0;
    v_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      v_frame = v_frame | (c_frame[i] & {FRAME_BITS{tail[i]}});
      v_page  = v_page | (c_page[i] & {PAGE_BITS{tail[i]}});
      v_dirty = v_dirty | (c_dirty[i] & tail[i]);
    end
  end

  always_comb begin
    out_word                                 = '0;
    out_word[1:0]                            = st_status;
    out_word[2]                              = st_hit;
    out_word[3]                              = c_valid[0];
    out_word[4 +: FRAME_BITS]                = v_frame;
    out_word[4 + FRAME_BITS +: PAGE_BITS]    = v_page;
    out_word[4 + FRAME_BITS + PAGE_BITS]     = v_dirty;
  end

  assign load          = pend && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !pend || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_status <= st_status_next;
      st_hit    <= hit;
    end
    if (load) begin
      m_axis_tdata <= out_word;
    end
  end

  a_valid_contiguous: assert property (@(posedge clk) disable iff (rst)
    (c_valid & (c_valid + 1'b1)) == '0)
    else $error("valid cells not contiguous from the head");

  a_frame_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("frame present in more than one cell");

  a_insert_head: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_TOUCH && !hit && !full |=>
      c_valid[0] && c_frame[0] == $past(in_frame) && !c_dirty[0])
    else $error("insert did not place a clean frame at the head");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_REMOVE && hit |=>
      $countones(c_valid) + 1 == $past($countones(c_valid)))
    else $error("remove did not drop exactly one entry");

  a_touch_hit_count: assert property (@(posedge clk) disable iff (rst)
    accept && func == FUNC_TOUCH && hit |=>
      $countones(c_valid) == $past($countones(c_valid)) &&
      c_frame[0] == $past(in_frame))
    else $error("touch of a present frame changed the entry count");

endmodule

// ===== rtl/lrt_cell.sv =====
// ----------------------------------------------------------------------------
// LRU recency tracker cell
// One list entry: compares its frame, passes the found-above flag down the
// chain and shifts toward its upper or lower neighbor on touch or remove.
// ----------------------------------------------------------------------------
module lrt_cell #(
  parameter int PAGE_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lrt_pkg::cell_ctl_t            ctl,
  input  logic                          prev_valid,
  input  logic [lrt_pkg::FRAME_BITS-1:0] prev_frame,
  input  logic [PAGE_BITS-1:0]          prev_page,
  input  logic                          prev_dirty,
  input  logic                          next_valid,
  input  logic [lrt_pkg::FRAME_BITS-1:0] next_frame,
  input  logic [PAGE_BITS-1:0]          next_page,
  input  logic                          next_dirty,
  input  logic                          before_in,
  output logic                          before_out,
  output logic                          match,
  output logic                          valid,
  output logic [lrt_pkg::FRAME_BITS-1:0] frame,
  output logic [PAGE_BITS-1:0]          page,
  output logic                          dirty
);
  import lrt_pkg::*;

  logic                  valid_next;
  logic [FRAME_BITS-1:0] frame_next;
  logic [PAGE_BITS-1:0]  page_next;
  logic                  dirty_next;
  logic                  take_prev;
  logic                  take_next;

  assign match      = valid && (frame == ctl.frame);
  assign before_out = before_in | match;

  always_comb begin
    take_prev  = 1'b0;
    take_next  = 1'b0;
    valid_next = valid;
    frame_next = frame;
    page_next  = page;
    dirty_next = dirty;
    if (ctl.en) begin
      unique case (ctl.func)
        FUNC_TOUCH: begin
          take_prev = ctl.hit ? !before_in : !ctl.full;
        end
        FUNC_REMOVE: begin
          take_next = ctl.hit && before_out;
        end
        FUNC_SET_DIRTY: begin
          if (match) begin
            dirty_next = 1'b1;
          end
        end
        FUNC_CLR_DIRTY: begin
          if (match) begin
            dirty_next = 1'b0;
          end
        end
      endcase
    end
    if (take_prev) begin
      valid_next = prev_valid;
      frame_next = prev_frame;
      page_next  = prev_page;
      dirty_next = prev_dirty;
    end else if (take_next) begin
      valid_next = next_valid;
      frame_next = next_frame;
      page_next  = next_page;
      dirty_next = next_dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    frame <= frame_next;
    page  <= page_next;
    dirty <= dirty_next;
  end

endmodule
